>>> design/dual_slot_record_validate_select_assert.svh
// Assertion macros shared by the validator's modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef DUAL_SLOT_RECORD_VALIDATE_SELECT_ASSERT_SVH
`define DUAL_SLOT_RECORD_VALIDATE_SELECT_ASSERT_SVH

`ifndef SYNTHESIS
`define DSRVS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define DSRVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DSRVS_ASSERT(lbl, prop, msg)
`define DSRVS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/dsrvs_pkg.sv
package dsrvs_pkg;

	localparam int AXES        = 3;
	localparam int AXW         = $clog2(AXES);
	localparam int REC_WORDS   = 12;
	localparam int TOTAL_WORDS = 24;
	localparam int CW          = $clog2(TOTAL_WORDS);

	localparam logic [31:0] MAGIC_WORD  = 32'h4746_5052;
	localparam logic [31:0] COMMIT_WORD = 32'h434F_4D54;
	localparam logic [31:0] VERLEN_WORD = 32'h0030_0001;
	localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

	// limit of 0.2 g in m/s^2 as raw single-precision bits
	localparam logic [30:0] LIMIT_RESET = 31'd1073417437;

	// word positions within one record
	localparam logic [3:0] POS_MAGIC  = 4'd0;
	localparam logic [3:0] POS_VERLEN = 4'd1;
	localparam logic [3:0] POS_SEQ    = 4'd2;
	localparam logic [3:0] POS_FLAGS  = 4'd3;
	localparam logic [3:0] POS_BIAS   = 4'd4;
	localparam logic [3:0] POS_RSVD   = POS_BIAS + 4'(AXES);
	localparam logic [3:0] POS_CRC    = 4'd10;
	localparam logic [3:0] POS_COMMIT = 4'd11;

	typedef enum logic [2:0] {
		LOAD_A,
		LOAD_B,
		LOAD_RECOV_A,
		LOAD_RECOV_B,
		LOAD_EMPTY,
		LOAD_CORRUPT
	} load_t;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t word;
		logic  start_req;
	} item_t;

	typedef struct packed {
		logic [2:0] load_code;
		logic       slot_sel;
		word_t      sequence_res;
		logic       store_ok;
		logic [1:0] invalid_slots;
		logic       calibrated;
		word_t      bias_x;
		word_t      bias_y;
		word_t      bias_z;
	} result_t;

	typedef struct packed {
		logic                  valid;
		logic                  blank;
		word_t                 seq;
		logic                  calib;
		word_t [AXES-1:0]      bias;
	} slot_sum_t;

	typedef struct packed {
		slot_sum_t a;
		slot_sum_t b;
	} slot_pair_t;

	// Parity masks of the reflected CRC-32 over one 32-bit word:
	// row j holds the input bits that feed output bit j.
	function automatic logic [31:0][31:0] crc_rows();
		logic [31:0][31:0] rows;
		logic [31:0]       c;
		rows = '0;
		for (int i = 0; i < 32; i++) begin
			c = 32'd1 << i;
			for (int k = 0; k < 32; k++) begin
				c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
			end
			for (int j = 0; j < 32; j++) begin
				rows[j][i] = c[j];
			end
		end
		return rows;
	endfunction

	function automatic word_t crc_step(word_t crc, word_t w, logic [31:0][31:0] rows);
		word_t v;
		word_t r;
		v = crc ^ w;
		for (int j = 0; j < 32; j++) begin
			r[j] = ^(v & rows[j]);
		end
		return r;
	endfunction

endpackage

>>> design/dsrvs_slot.sv
`include "dual_slot_record_validate_select_assert.svh"

module dsrvs_slot (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  dsrvs_pkg::item_t        item_s1,
	input  logic [30:0]             bias_limit,
	output logic                    emit,
	output dsrvs_pkg::slot_pair_t   pair
);
	import dsrvs_pkg::*;

	localparam logic [31:0][31:0] CRC_ROWS = crc_rows();

	logic [CW-1:0]    wc_q;
	word_t            crc_q;
	logic             blank_q;
	logic             ok_q;
	word_t            seq_q;
	logic             calib_q;
	word_t [AXES-1:0] bias_q;
	slot_sum_t        first_q;

	logic [CW-1:0]    idx_raw;
	logic [CW-1:0]    idx;
	logic             slot_b;
	logic [3:0]       pos;
	logic             clear;
	word_t            w;
	word_t            crc_b;
	logic             blank_b;
	logic             ok_b;
	word_t            seq_b;
	logic             calib_b;
	word_t [AXES-1:0] bias_b;
	word_t            crc_n;
	logic             blank_n;
	logic             bad;
	logic             bias_good;
	logic [AXW-1:0]   bias_sel;
	logic             in_bias;
	word_t [AXES-1:0] bias_n;
	logic             rec_valid;

	always_comb begin
		w       = item_s1.word;
		idx_raw = item_s1.start_req ? '0 : wc_q;
		idx     = (idx_raw >= CW'(TOTAL_WORDS)) ? '0 : idx_raw;
		slot_b  = idx >= CW'(REC_WORDS);
		pos     = slot_b ? 4'(idx - CW'(REC_WORDS)) : 4'(idx);
		clear   = pos == POS_MAGIC;
		emit    = slot_b && (pos == POS_COMMIT);

		crc_b   = clear ? CRC_INIT : crc_q;
		blank_b = clear ? 1'b1 : blank_q;
		ok_b    = clear ? 1'b1 : ok_q;
		seq_b   = clear ? '0 : seq_q;
		calib_b = clear ? 1'b0 : calib_q;
		bias_b  = clear ? '0 : bias_q;

		blank_n = blank_b && (w == ALL_ONES);
		crc_n   = (pos < POS_CRC) ? crc_step(crc_b, w, CRC_ROWS) : crc_b;

		// infinity and NaN always fail
		bias_good = !(&w[30:23]) && (w[30:0] <= bias_limit);
		in_bias   = pos inside {[POS_BIAS:POS_RSVD - 4'd1]};
		bias_sel  = AXW'(pos - POS_BIAS);
		for (int a = 0; a < AXES; a++) begin
			bias_n[a] = (in_bias && bias_sel == AXW'(a)) ? w : bias_b[a];
		end

		bad = 1'b0;
		case (pos)
			POS_MAGIC:  bad = w != MAGIC_WORD;
			POS_VERLEN: bad = w != VERLEN_WORD;
			POS_SEQ:    bad = w == '0;
			POS_FLAGS:  bad = w[31:1] != '0;
			POS_CRC:    bad = w != ~crc_b;
			default: begin
				if (in_bias) begin
					bad = calib_b && !bias_good;
				end else if (pos inside {[POS_RSVD:POS_CRC - 4'd1]}) begin
					bad = w != '0;
				end
			end
		endcase

		rec_valid = ok_b && (w == COMMIT_WORD);

		pair.a       = first_q;
		pair.b.valid = rec_valid;
		pair.b.blank = blank_n;
		pair.b.seq   = seq_b;
		pair.b.calib = calib_b;
		pair.b.bias  = bias_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q    <= '0;
			crc_q   <= CRC_INIT;
			blank_q <= 1'b1;
			ok_q    <= 1'b1;
			seq_q   <= '0;
			calib_q <= 1'b0;
			bias_q  <= '0;
			first_q <= '0;
		end else if (step) begin
			wc_q    <= emit ? '0 : idx + CW'(1);
			crc_q   <= crc_n;
			blank_q <= blank_n;
			ok_q    <= ok_b && !bad;
			seq_q   <= (pos == POS_SEQ) ? w : seq_b;
			calib_q <= (pos == POS_FLAGS) ? w[0] : calib_b;
			bias_q  <= bias_n;
			if (!slot_b && pos == POS_COMMIT) begin
				first_q.valid <= rec_valid;
				first_q.blank <= blank_n;
				first_q.seq   <= seq_b;
				first_q.calib <= calib_b;
				first_q.bias  <= bias_b;
			end
		end
	end

	`DSRVS_ASSERT(a_count_range, wc_q < CW'(TOTAL_WORDS), "word counter out of range")
	`DSRVS_ASSERT_NEXT(a_emit_wraps, step && emit, wc_q == '0, "counter did not wrap after slot B")
	`DSRVS_ASSERT_NEXT(a_start_resync, step && item_s1.start_req, wc_q == CW'(1), "start did not resync counter")

endmodule

>>> design/dsrvs_select.sv
module dsrvs_select (
	input  dsrvs_pkg::slot_pair_t pair,
	output dsrvs_pkg::result_t    res
);
	import dsrvs_pkg::*;

	logic  a_bad;
	logic  b_bad;
	logic  pick_a;
	logic  pick_b;
	logic  newer_b;
	word_t diff;
	load_t load;
	slot_sum_t chosen;

	always_comb begin
		a_bad   = !pair.a.blank && !pair.a.valid;
		b_bad   = !pair.b.blank && !pair.b.valid;
		// wrapping compare: B is newer when the difference is positive
		diff    = pair.b.seq - pair.a.seq;
		newer_b = (diff != '0) && !diff[31];
		pick_a  = 1'b0;
		pick_b  = 1'b0;

		if (pair.a.valid && pair.b.valid) begin
			pick_b = newer_b;
			pick_a = !newer_b;
			load   = newer_b ? LOAD_B : LOAD_A;
		end else if (pair.a.valid) begin
			pick_a = 1'b1;
			load   = b_bad ? LOAD_RECOV_A : LOAD_A;
		end else if (pair.b.valid) begin
			pick_b = 1'b1;
			load   = a_bad ? LOAD_RECOV_B : LOAD_B;
		end else begin
			load   = (pair.a.blank && pair.b.blank) ? LOAD_EMPTY : LOAD_CORRUPT;
		end

		chosen = pick_b ? pair.b : (pick_a ? pair.a : '0);

		res.load_code     = load;
		res.slot_sel      = pick_b;
		res.sequence_res  = chosen.seq;
		res.store_ok      = pick_a || pick_b || (pair.a.blank && pair.b.blank);
		res.invalid_slots = {b_bad, a_bad};
		res.calibrated    = chosen.calib;
		res.bias_x        = chosen.calib ? chosen.bias[0] : '0;
		res.bias_y        = chosen.calib ? chosen.bias[1] : '0;
		res.bias_z        = chosen.calib ? chosen.bias[2] : '0;
	end

endmodule

>>> design/dual_slot_record_validate_select.sv
// Dual-slot record validator and selector.
// Input channel (item_valid / item_stall / item): one 32-bit record word per
// transaction, slot A words 0-11 followed by slot B words 12-23. start_req
// marks slot A word 0 and drops any partial pair.
// Result channel (result_valid / result_stall / result): one transaction per
// 24 words, carrying the chosen slot, load code, invalid mask and biases.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): the bias limit,
// always ready; write it only while no words are in flight.
// Throughput: one word per cycle while item_stall is low. Each word is
// registered, then checked (parallel CRC-32 update, field compares, slot
// choice) combinationally; the result register loads when word 23 advances
// out of the input register.
// Reset clears the word counter, slot state and both valid flags; the bias
// limit returns to its default of 0.2 g.
// While the receiver stalls, the result is held and words keep flowing;
// only when a second result is ready behind a held one does item_stall rise.
`include "dual_slot_record_validate_select_assert.svh"

module dual_slot_record_validate_select (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dsrvs_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_stall,
	output dsrvs_pkg::result_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [30:0]         cfg_data
);
	import dsrvs_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic [30:0] bias_limit_q;
	logic        res_valid_q;
	result_t     result_q;

	logic        emit;
	logic        s1_go;
	logic        item_take;
	slot_pair_t  pair;
	result_t     res_next;

	// Advance the stage-one word unless it completes a pair and the held
	// result has not been taken yet.
	assign s1_go      = valid_s1 && (!emit || !res_valid_q || !result_stall);
	assign item_stall = valid_s1 && !s1_go;
	assign item_take  = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	assign result_valid = res_valid_q;
	assign result       = result_q;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bias_limit_q <= cfg_data;
		end
	end

	// Input register: take a new word when it is empty or the current one advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
	end

	dsrvs_slot u_slot (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_go),
		.item_s1    (item_s1),
		.bias_limit (bias_limit_q),
		.emit       (emit),
		.pair       (pair)
	);

	dsrvs_select u_select (
		.pair (pair),
		.res  (res_next)
	);

	// Result register: load on a completed pair, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			result_q <= res_next;
		end
	end

	`DSRVS_ASSERT_NEXT(a_s1_held, valid_s1 && !s1_go, valid_s1, "stage-one word dropped")
	`DSRVS_ASSERT(a_result_source, $rose(res_valid_q) |-> $past(s1_go && emit), "stray result")
	`DSRVS_ASSERT_NEXT(a_load_code, s1_go && emit, result_q.load_code <= LOAD_CORRUPT, "bad load")

endmodule

>>> verif/record_select_checker.sv
`timescale 1ns / 1ps

module record_select_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  dsrvs_pkg::item_t    item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  dsrvs_pkg::result_t  result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [30:0]         cfg_data,
	output int                  mismatches,
	output int                  outstanding
);
	import dsrvs_pkg::*;

	logic [30:0] limit_bits;
	logic [4:0]  word_idx;
	word_t       crc_acc;
	logic        rec_blank, rec_sound, rec_calib;
	word_t       rec_seq;
	word_t       rec_bias [AXES];
	logic        a_valid, a_blank, a_calib;
	word_t       a_seq;
	word_t       a_bias [AXES];
	result_t     selection_q [$];

	// byte-wise reflected CRC-32, low byte first
	function automatic word_t crc_fold(word_t crc, word_t w);
		word_t c;
		c = crc;
		for (int b = 0; b < 4; b++) begin
			c ^= {24'd0, w[8*b +: 8]};
			for (int k = 0; k < 8; k++) begin
				c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
			end
		end
		return c;
	endfunction

	// infinity and NaN always fail
	function automatic logic bias_in_bounds(word_t w);
		logic [30:0] mag;
		mag = w[30:0];
		if (&mag[30:23]) begin
			return 1'b0;
		end
		return mag <= limit_bits;
	endfunction

	task automatic take_word(input word_t w, input logic restart);
		logic [4:0] idx;
		logic [3:0] pos;
		logic       rec_ok, a_bad, b_bad, take_a, take_b;
		word_t      gap;
		result_t    sel;
		idx = restart ? 5'd0 : word_idx;
		if (idx >= 5'(TOTAL_WORDS)) begin
			idx = 5'd0;
		end
		pos = (idx >= 5'(REC_WORDS)) ? 4'(idx - 5'(REC_WORDS)) : idx[3:0];
		if (pos == POS_MAGIC) begin
			crc_acc   = CRC_INIT;
			rec_blank = 1'b1;
			rec_sound = 1'b1;
			rec_seq   = '0;
			rec_calib = 1'b0;
			for (int a = 0; a < AXES; a++) begin
				rec_bias[a] = '0;
			end
		end
		if (w != ALL_ONES) begin
			rec_blank = 1'b0;
		end
		if (pos < POS_CRC) begin
			crc_acc = crc_fold(crc_acc, w);
		end
		if (pos == POS_MAGIC) begin
			rec_sound &= (w == MAGIC_WORD);
		end else if (pos == POS_VERLEN) begin
			rec_sound &= (w == VERLEN_WORD);
		end else if (pos == POS_SEQ) begin
			rec_seq = w;
			rec_sound &= (w != '0);
		end else if (pos == POS_FLAGS) begin
			rec_calib = w[0];
			rec_sound &= (w[31:1] == '0);
		end else if (pos < POS_RSVD) begin
			rec_bias[pos - POS_BIAS] = w;
			if (rec_calib && !bias_in_bounds(w)) begin
				rec_sound = 1'b0;
			end
		end else if (pos < POS_CRC) begin
			rec_sound &= (w == '0);
		end else if (pos == POS_CRC) begin
			rec_sound &= (w == ~crc_acc);
		end

		if (pos != POS_COMMIT) begin
			word_idx = idx + 5'd1;
			return;
		end
		rec_ok = rec_sound && (w == COMMIT_WORD);

		// end of slot A: park its summary
		if (idx < 5'(REC_WORDS)) begin
			a_valid = rec_ok;
			a_blank = rec_blank;
			a_seq   = rec_seq;
			a_calib = rec_calib;
			for (int a = 0; a < AXES; a++) begin
				a_bias[a] = rec_bias[a];
			end
			word_idx = idx + 5'd1;
			return;
		end

		word_idx = '0;
		a_bad    = !a_blank && !a_valid;
		b_bad    = !rec_blank && !rec_ok;
		take_a   = 1'b0;
		take_b   = 1'b0;
		sel      = '0;
		if (a_valid && rec_ok) begin
			// newer sequence wins, compared with wrap
			gap    = rec_seq - a_seq;
			take_b = (gap != '0) && !gap[31];
			take_a = !take_b;
			sel.load_code = take_b ? LOAD_B : LOAD_A;
		end else if (a_valid) begin
			take_a = 1'b1;
			sel.load_code = b_bad ? LOAD_RECOV_A : LOAD_A;
		end else if (rec_ok) begin
			take_b = 1'b1;
			sel.load_code = a_bad ? LOAD_RECOV_B : LOAD_B;
		end else begin
			sel.load_code = (a_blank && rec_blank) ? LOAD_EMPTY : LOAD_CORRUPT;
		end
		if (take_a) begin
			sel.sequence_res = a_seq;
			sel.calibrated   = a_calib;
			if (a_calib) begin
				sel.bias_x = a_bias[0];
				sel.bias_y = a_bias[1];
				sel.bias_z = a_bias[2];
			end
		end
		if (take_b) begin
			sel.slot_sel     = 1'b1;
			sel.sequence_res = rec_seq;
			sel.calibrated   = rec_calib;
			if (rec_calib) begin
				sel.bias_x = rec_bias[0];
				sel.bias_y = rec_bias[1];
				sel.bias_z = rec_bias[2];
			end
		end
		sel.store_ok      = take_a || take_b || (a_blank && rec_blank);
		sel.invalid_slots = {b_bad, a_bad};
		selection_q.push_back(sel);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (selection_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected result @%0t: load %0d slot %0d seq %h", $time,
					got.load_code, got.slot_sel, got.sequence_res);
			end
			return;
		end
		want = selection_q.pop_front();
		if (got.load_code !== want.load_code || got.slot_sel !== want.slot_sel
				|| got.sequence_res !== want.sequence_res
				|| got.store_ok !== want.store_ok
				|| got.invalid_slots !== want.invalid_slots
				|| got.calibrated !== want.calibrated || got.bias_x !== want.bias_x
				|| got.bias_y !== want.bias_y || got.bias_z !== want.bias_z) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result mismatch @%0t", $time);
				$display("  want load %0d slot %0d seq %h ok %0d bad %b cal %0d bias %h %h %h",
					want.load_code, want.slot_sel, want.sequence_res,
					want.store_ok, want.invalid_slots, want.calibrated,
					want.bias_x, want.bias_y, want.bias_z);
				$display("  got  load %0d slot %0d seq %h ok %0d bad %b cal %0d bias %h %h %h",
					got.load_code, got.slot_sel, got.sequence_res,
					got.store_ok, got.invalid_slots, got.calibrated,
					got.bias_x, got.bias_y, got.bias_z);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_bits = LIMIT_RESET;
			word_idx   = '0;
			crc_acc    = CRC_INIT;
			rec_blank  = 1'b1;
			rec_sound  = 1'b1;
			rec_seq    = '0;
			rec_calib  = 1'b0;
			a_valid    = 1'b0;
			a_blank    = 1'b0;
			a_seq      = '0;
			a_calib    = 1'b0;
			for (int a = 0; a < AXES; a++) begin
				rec_bias[a] = '0;
				a_bias[a]   = '0;
			end
			selection_q.delete();
			mismatches = 0;
		end else begin
			if (result_valid && !result_stall) begin
				check_result(result);
			end
			if (cfg_valid && cfg_ready) begin
				limit_bits = cfg_data;
			end
			if (item_valid && !item_stall) begin
				take_word(item.word, item.start_req);
			end
		end
		outstanding = selection_q.size();
	end

endmodule

>>> verif/tb_dual_slot_record_validate_select.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the dual-slot record validator. The checker beside
// the block watches every channel, predicts each selection and compares.
module tb_dual_slot_record_validate_select;
	import dsrvs_pkg::*;

	localparam int          HOLD_CYCLES   = 300;
	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          PHASE_WORDS   = 230;
	localparam logic [30:0] LIMIT_MAX     = 31'h7F7F_FFFF;

	typedef word_t [REC_WORDS-1:0] record_t;

	// ways of spoiling one record
	typedef enum int {
		FLAW_NONE,
		FLAW_BLANK,
		FLAW_MAGIC,
		FLAW_VERLEN,
		FLAW_SEQ_ZERO,
		FLAW_FLAGS,
		FLAW_RSVD,
		FLAW_BIAS,
		FLAW_CRC,
		FLAW_COMMIT,
		FLAW_JUNK
	} flaw_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	item_t       item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [30:0] cfg_data     = '0;

	int          mismatches;
	int          outstanding;
	int          idle_pct     = 0;
	int          stall_pct    = 0;
	logic        hold_request = 1'b0;
	int          held_cycles  = 0;
	int          cycle_count  = 0;
	int          words_sent   = 0;
	logic        aligned      = 1'b0;
	logic [30:0] limit_now    = LIMIT_RESET;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	dual_slot_record_validate_select u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	record_select_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Result side: stall at the phase's rate. Once a hold-off is requested,
	// hold the stall for a long stretch so the block backs up into its input.
	always @(negedge clk) begin
		if (hold_request && held_cycles < HOLD_CYCLES) begin
			held_cycles  <= held_cycles + 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_dual_slot_record_validate_select: done, errors");
			$finish;
		end
	end

	// Reference CRC over words 0..9, stored inverted as in the record.
	function automatic word_t crc_of(record_t r);
		word_t c;
		c = CRC_INIT;
		for (int i = 0; i < POS_CRC; i++) begin
			for (int b = 0; b < 4; b++) begin
				c ^= {24'd0, r[i][8*b +: 8]};
				for (int k = 0; k < 8; k++) begin
					c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
				end
			end
		end
		return ~c;
	endfunction

	// Bias that passes the check: up to and including the limit, either sign.
	function automatic word_t bias_within();
		logic [30:0] mag;
		mag = ($urandom_range(0, 3) == 0) ? limit_now : 31'($urandom_range(0, limit_now));
		return {1'($urandom_range(0, 1)), mag};
	endfunction

	// Bias that fails: just over the limit, anywhere above it, or inf / NaN.
	function automatic word_t bias_beyond();
		logic [30:0] mag;
		case ($urandom_range(0, 2))
			0:       mag = limit_now + 31'd1;
			1:       mag = 31'($urandom_range(limit_now + 31'd1, 32'h7FFF_FFFF));
			default: mag = {8'hFF, 23'($urandom())};
		endcase
		return {1'($urandom_range(0, 1)), mag};
	endfunction

	function automatic record_t make_record(word_t seq, flaw_t flaw);
		record_t r;
		logic    calib;
		int      bad_axis;
		calib    = (flaw == FLAW_BIAS) ? 1'b1 : 1'($urandom_range(0, 1));
		bad_axis = (flaw == FLAW_BIAS) ? $urandom_range(0, AXES - 1) : -1;
		r = '0;
		r[POS_MAGIC]  = MAGIC_WORD;
		r[POS_VERLEN] = VERLEN_WORD;
		r[POS_SEQ]    = seq;
		r[POS_FLAGS]  = {31'd0, calib};
		for (int a = 0; a < AXES; a++) begin
			if (a == bad_axis) begin
				r[POS_BIAS + a] = bias_beyond();
			end else begin
				// uncalibrated biases go unchecked, so anything goes
				r[POS_BIAS + a] = calib ? bias_within() : $urandom();
			end
		end
		case (flaw)
			FLAW_MAGIC:    r[POS_MAGIC] ^= 32'd1 << $urandom_range(0, 31);
			FLAW_VERLEN: begin
				case ($urandom_range(0, 2))
					0:       r[POS_VERLEN] = 32'h0030_0002;
					1:       r[POS_VERLEN] = 32'h002F_0001;
					default: r[POS_VERLEN] = $urandom();
				endcase
			end
			FLAW_SEQ_ZERO: r[POS_SEQ] = '0;
			FLAW_FLAGS:    r[POS_FLAGS][$urandom_range(1, 31)] = 1'b1;
			FLAW_RSVD:     r[POS_RSVD + $urandom_range(0, POS_CRC - POS_RSVD - 1)] =
				$urandom() | (32'd1 << $urandom_range(0, 31));
			default: ;
		endcase
		// reseal so only the intended field is wrong
		r[POS_CRC]    = crc_of(r);
		r[POS_COMMIT] = COMMIT_WORD;
		if (flaw == FLAW_CRC) begin
			r[POS_CRC] ^= 32'd1 << $urandom_range(0, 31);
		end
		if (flaw == FLAW_COMMIT) begin
			r[POS_COMMIT] ^= 32'd1 << $urandom_range(0, 31);
		end
		if (flaw == FLAW_BLANK) begin
			r = '1;
		end
		if (flaw == FLAW_JUNK) begin
			for (int i = 0; i < REC_WORDS; i++) begin
				r[i] = $urandom();
			end
		end
		return r;
	endfunction

	function automatic flaw_t pick_flaw();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			return FLAW_NONE;
		end
		if (roll < 65) begin
			return FLAW_BLANK;
		end
		return flaw_t'($urandom_range(int'(FLAW_MAGIC), int'(FLAW_JUNK)));
	endfunction

	// Offer one word; called and left at a falling edge. Valid stays high
	// into the next call unless that call idles first.
	task automatic send_word(input word_t w, input logic restart);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{word: w, start_req: restart};
		do begin
			@(posedge clk);
		end while (item_stall);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_pair();
		record_t ra, rb;
		word_t   sa, sb;
		logic    lead;
		sa = $urandom();
		if (sa == '0) begin
			sa = 32'd1;
		end
		// spread the sequence relation over the wrap cases
		case ($urandom_range(0, 5))
			0:       sb = sa + 32'd1;
			1:       sb = sa - 32'd1;
			2:       sb = sa;
			3:       sb = sa ^ 32'h8000_0000;
			4: begin
				sa = ALL_ONES;
				sb = 32'd1;
			end
			default: sb = $urandom();
		endcase
		if ($urandom_range(0, 9) == 0) begin
			ra = make_record(sa, FLAW_BLANK);
			rb = make_record(sb, FLAW_BLANK);
		end else begin
			ra = make_record(sa, pick_flaw());
			rb = make_record(sb, pick_flaw());
		end
		// once in step, the start flag is optional
		lead = !aligned || $urandom_range(0, 1);
		for (int i = 0; i < REC_WORDS; i++) begin
			send_word(ra[i], i == 0 && lead);
		end
		for (int i = 0; i < REC_WORDS; i++) begin
			send_word(rb[i], 1'b0);
		end
		aligned = 1'b1;
	endtask

	// Broken sequences: an abandoned record prefix or plain junk with
	// stray start flags.
	task automatic send_noise();
		record_t ra;
		int      n;
		ra = make_record($urandom() | 32'd1, FLAW_NONE);
		n  = $urandom_range(1, 30);
		for (int i = 0; i < n; i++) begin
			if (i < REC_WORDS && $urandom_range(0, 1)) begin
				send_word(ra[i], i == 0);
			end else begin
				send_word($urandom(), $urandom_range(0, 9) == 0);
			end
		end
		aligned = 1'b0;
	endtask

	// Drop valid and wait for every selection, then for the tail of any
	// partial record still in the pipeline.
	task automatic drain();
		item_valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [30:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		limit_now = v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		record_t ra;
		int      phase_end;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extreme words with a start mid-stream, then a calibrated A
		// with biases exactly at the limit (both signs) and zero, B blank.
		send_word(ALL_ONES, 1'b1);
		send_word('0, 1'b0);
		ra                = make_record(32'd1, FLAW_NONE);
		ra[POS_FLAGS]     = 32'd1;
		ra[POS_BIAS]      = {1'b1, limit_now};
		ra[POS_BIAS + 1]  = '0;
		ra[POS_BIAS + 2]  = {1'b0, limit_now};
		ra[POS_CRC]       = crc_of(ra);
		for (int i = 0; i < REC_WORDS; i++) begin
			send_word(ra[i], i == 0);
		end
		for (int i = 0; i < REC_WORDS; i++) begin
			send_word(ALL_ONES, 1'b0);
		end
		aligned = 1'b1;

		// Random phases, each with its own limit and idling mix.
		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				drain();
				case (p)
					1:       write_limit('0);
					2:       write_limit(LIMIT_MAX);
					3:       write_limit(31'($urandom_range(0, LIMIT_MAX)));
					default: write_limit(31'($urandom_range(32'h3C00_0000, 32'h4080_0000)));
				endcase
			end
			case (p)
				1: begin
					idle_pct  = 69;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 69;
				end
				3: begin
					idle_pct  = 32;
					stall_pct = 32;
				end
				default: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
			endcase
			// long result hold-off while words keep coming
			if (p == 0) begin
				hold_request = 1'b1;
			end
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					send_noise();
				end else begin
					send_pair();
				end
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("tb_dual_slot_record_validate_select: done, clean");
		end else begin
			$display("tb_dual_slot_record_validate_select: done, errors");
		end
		$finish;
	end

endmodule
